@@ src/crsa_pkg.sv @@
// Package for the complex RPN stack ALU: word types, op and status codes,
// and shared sizes. Used by every module under src.
`default_nettype none
package crsa_pkg;
   localparam int StackDepth = 16;
   localparam int FracBits   = 16;
   localparam int CntW       = $clog2(StackDepth + 1);

   typedef enum logic [2:0] {
      OP_PUSH = 3'd0, OP_ADD = 3'd1, OP_SUB = 3'd2,
      OP_MUL = 3'd3, OP_DIV = 3'd4, OP_CLR = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_FEW = 2'd1, ST_DIV0 = 2'd2, ST_FULL = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_SUM, S_DIV, S_WRITE, S_OUT
   } state_type;

   // shift action applied to every cell of the stack
   typedef enum logic [1:0] {
      SH_HOLD, SH_PUSH, SH_POP
   } shift_type;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] real_part;
      logic signed [31:0] imag_part;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] top_real;
      logic signed [31:0] top_imag;
      logic [4:0]         depth;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      shift_type    shift;
      logic [63:0]  data;
   } cell_ctl_type;
endpackage
`default_nettype wire

@@ src/complex_rpn_stack_alu_unit.sv @@
// Complex RPN stack ALU top level: request/response words over valid/stall.
// Depends on crsa_pkg, crsa_cell and crsa_div.
//
// Each request word carries an op and a Q16.16 complex value used by push.
// Exactly one response word comes back per request: status, new top element,
// depth and a saturation flag. One word is in flight at a time; req_stall is
// high from acceptance until the response has been taken.
// Path from acceptance to rsp_valid: push, clear, add, sub, unknown ops and too
// few operands go through S_WRITE and S_OUT; multiply first forms four 32x32
// products on one shared multiplier; a zero divisor is found after six products;
// divide forms six products, then two restoring divides on one bit-serial divider.
// The next request is taken the cycle after the response word is accepted.
// The stack is a row of StackDepth shifting cells with the top in cell 0.
// Reset empties the stack at once; element contents are not cleared.
// While a response is valid and rsp_stall is high, the word holds and no request is taken.
`default_nettype none
module complex_rpn_stack_alu_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire crsa_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output crsa_pkg::rsp_type      rsp_data
);
   localparam int N = crsa_pkg::StackDepth;
   localparam int CW = crsa_pkg::CntW;

   crsa_pkg::state_type state_ff, state_in;
   crsa_pkg::req_type   req_ff, req_in;
   crsa_pkg::rsp_type   rsp_ff, rsp_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [2:0]          step_ff, step_in;
   logic signed [63:0]  p_ff [4];
   logic signed [63:0]  p_in;
   logic [63:0]         a_ff, a_in, b_ff, b_in, den_ff, den_in;
   logic                an_ff, an_in, bn_ff, bn_in;
   logic [31:0]         rr_ff, rr_in, ri_ff, ri_in;
   logic                sat_ff, sat_in;
   logic                part_ff, part_in;
   crsa_pkg::cell_ctl_type ctl;
   logic [63:0]         cell_q [N];
   logic                div_start, div_done;
   logic [32:0]         quot;
   logic signed [31:0]  tr, tm, sr, sm, ma, mb;

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         crsa_cell u_cell (
            .clock(clock), .ctl(ctl),
            .above_data(g == 0 ? 64'd0 : cell_q[(g == 0) ? 0 : g-1]),
            .below_data(g == N-1 ? 64'd0 : cell_q[(g == N-1) ? 0 : g+1]),
            .is_top(g == 0), .data(cell_q[g])
         );
      end
   endgenerate

   crsa_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(part_ff ? b_ff : a_ff), .den(den_ff), .done(div_done), .quot(quot)
   );

   assign tr = cell_q[0][63:32];
   assign tm = cell_q[0][31:0];
   assign sr = cell_q[1][63:32];
   assign sm = cell_q[1][31:0];

   always_comb begin
      case (step_ff)
         3'd0:    begin ma = tr; mb = sr; end
         3'd1:    begin ma = tm; mb = sm; end
         3'd2:    begin ma = tr; mb = sm; end
         3'd3:    begin ma = tm; mb = sr; end
         3'd4:    begin ma = sr; mb = sr; end
         default: begin ma = sm; mb = sm; end
      endcase
      p_in = ma * mb;
   end

   function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] mag);
      logic [32:0] r;
      begin
         r = '0;
         if (neg) begin
            if (mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
            else r = {1'b0, 32'(64'd0 - mag)};
         end else begin
            if (mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
            else r = {1'b0, mag[31:0]};
         end
         return r;
      end
   endfunction

   // two's complement 64-bit pattern to sign/magnitude (2^63 is positive)
   function automatic logic [64:0] to_sm(input logic [63:0] p);
      begin
         if (p == 64'h8000_0000_0000_0000) return {1'b0, p};
         else if (p[63]) return {1'b1, 64'd0 - p};
         else return {1'b0, p};
      end
   endfunction

   logic [32:0] s_re, s_im, s_q;
   logic [64:0] sa, sb;
   logic [63:0] add_re, add_im;

   always_comb begin
      state_in = state_ff; req_in = req_ff; rsp_in = rsp_ff; cnt_in = cnt_ff;
      step_in = step_ff; a_in = a_ff; b_in = b_ff; den_in = den_ff;
      an_in = an_ff; bn_in = bn_ff; rr_in = rr_ff; ri_in = ri_ff;
      sat_in = sat_ff; part_in = part_ff; div_start = 1'b0;
      ctl.shift = crsa_pkg::SH_HOLD; ctl.data = '0;
      sa = '0; sb = '0; s_re = '0; s_im = '0; s_q = '0;
      add_re = '0; add_im = '0;
      case (state_ff)
         crsa_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in = req_data; step_in = '0; sat_in = 1'b0; part_in = 1'b0;
               rsp_in.status = crsa_pkg::ST_OK;
               state_in = crsa_pkg::S_WRITE;
               case (req_data.op)
                  crsa_pkg::OP_ADD, crsa_pkg::OP_SUB, crsa_pkg::OP_MUL,
                  crsa_pkg::OP_DIV: begin
                     if (cnt_ff < CW'(2)) rsp_in.status = crsa_pkg::ST_FEW;
                     else if (req_data.op == crsa_pkg::OP_MUL ||
                              req_data.op == crsa_pkg::OP_DIV)
                        state_in = crsa_pkg::S_MUL;
                  end
                  default: ;
               endcase
            end
         end
         crsa_pkg::S_MUL: begin
            step_in = step_ff + 3'd1;
            if ((req_ff.op == crsa_pkg::OP_MUL && step_ff == 3'd3) ||
                step_ff == 3'd5)
               state_in = crsa_pkg::S_SUM;
         end
         crsa_pkg::S_SUM: begin
            if (req_ff.op == crsa_pkg::OP_MUL) begin
               sa = to_sm(64'(p_ff[0] - p_ff[1]));
               sb = to_sm(64'(p_ff[2] + p_ff[3]));
               s_re = sat_mag(sa[64], sa[63:0] >> crsa_pkg::FracBits);
               s_im = sat_mag(sb[64], sb[63:0] >> crsa_pkg::FracBits);
               rr_in = s_re[31:0]; ri_in = s_im[31:0];
               sat_in = s_re[32] | s_im[32];
               state_in = crsa_pkg::S_WRITE;
            end else begin
               // p_ff now holds Tr*Sr, Ti*Si, Tr*Si, Ti*Sr; den from last two
               sa = to_sm(64'(p_ff[0] + p_ff[1]));
               sb = to_sm(64'(p_ff[3] - p_ff[2]));
               a_in = sa[63:0]; an_in = sa[64];
               b_in = sb[63:0]; bn_in = sb[64];
               den_in = den_ff;
               if (den_ff == 64'd0) begin
                  rsp_in.status = crsa_pkg::ST_DIV0;
                  state_in = crsa_pkg::S_WRITE;
               end else begin
                  state_in = crsa_pkg::S_DIV;
               end
            end
         end
         crsa_pkg::S_DIV: begin
            if (step_ff != 3'd7) begin
               div_start = 1'b1; step_in = 3'd7;
            end else if (div_done) begin
               s_q = sat_mag(part_ff ? bn_ff : an_ff, {31'd0, quot});
               if (part_ff) begin
                  ri_in = s_q[31:0]; sat_in = sat_ff | s_q[32];
                  state_in = crsa_pkg::S_WRITE;
               end else begin
                  rr_in = s_q[31:0]; sat_in = s_q[32];
                  part_in = 1'b1; step_in = 3'd0;
               end
            end
         end
         crsa_pkg::S_WRITE: begin
            state_in = crsa_pkg::S_OUT;
            if (rsp_ff.status == crsa_pkg::ST_OK) begin
               case (req_ff.op)
                  crsa_pkg::OP_PUSH: begin
                     if (cnt_ff >= CW'(N)) rsp_in.status = crsa_pkg::ST_FULL;
                     else begin
                        ctl.shift = crsa_pkg::SH_PUSH;
                        ctl.data = {req_ff.real_part, req_ff.imag_part};
                        cnt_in = cnt_ff + CW'(1);
                     end
                  end
                  crsa_pkg::OP_ADD, crsa_pkg::OP_SUB: begin
                     if (req_ff.op == crsa_pkg::OP_ADD) begin
                        add_re = 64'(64'(tr) + 64'(sr));
                        add_im = 64'(64'(tm) + 64'(sm));
                     end else begin
                        add_re = 64'(64'(tr) - 64'(sr));
                        add_im = 64'(64'(tm) - 64'(sm));
                     end
                     sa = to_sm(add_re); sb = to_sm(add_im);
                     s_re = sat_mag(sa[64], sa[63:0]);
                     s_im = sat_mag(sb[64], sb[63:0]);
                     sat_in = s_re[32] | s_im[32];
                     ctl.shift = crsa_pkg::SH_POP;
                     ctl.data = {s_re[31:0], s_im[31:0]};
                     cnt_in = cnt_ff - CW'(1);
                  end
                  crsa_pkg::OP_MUL, crsa_pkg::OP_DIV: begin
                     ctl.shift = crsa_pkg::SH_POP;
                     ctl.data = {rr_ff, ri_ff};
                     cnt_in = cnt_ff - CW'(1);
                  end
                  crsa_pkg::OP_CLR: cnt_in = '0;
                  default: ;
               endcase
            end
         end
         crsa_pkg::S_OUT: begin
            rsp_in.top_real = (cnt_ff != '0) ? tr : 32'sd0;
            rsp_in.top_imag = (cnt_ff != '0) ? tm : 32'sd0;
            rsp_in.depth = 5'(cnt_ff);
            rsp_in.saturated = (rsp_ff.status == crsa_pkg::ST_OK) ? sat_ff : 1'b0;
            state_in = crsa_pkg::S_IDLE;
         end
         default: state_in = crsa_pkg::S_IDLE;
      endcase
   end

   logic rsp_valid_ff, rsp_valid_in;
   assign rsp_valid_in = (state_ff == crsa_pkg::S_OUT) ? 1'b1 :
                         (rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crsa_pkg::S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff <= '0;
         part_ff <= 1'b0;
      end else begin
         // stay idle while a response is pending so the output is not overrun
         if (state_ff == crsa_pkg::S_IDLE && rsp_valid_ff) state_ff <= crsa_pkg::S_IDLE;
         else state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff <= step_in;
         part_ff <= part_in;
      end
      req_ff <= req_in; a_ff <= a_in; b_ff <= b_in;
      an_ff <= an_in; bn_ff <= bn_in; rr_ff <= rr_in; ri_ff <= ri_in;
      sat_ff <= sat_in;
      if (!(state_ff == crsa_pkg::S_IDLE && rsp_valid_ff)) rsp_ff <= rsp_in;
      if (state_ff == crsa_pkg::S_MUL) begin
         if (step_ff < 3'd4) p_ff[step_ff[1:0]] <= p_in;
      end
      if (state_ff == crsa_pkg::S_MUL && step_ff == 3'd4) den_ff <= 64'(p_in);
      else if (state_ff == crsa_pkg::S_MUL && step_ff == 3'd5)
         den_ff <= den_ff + 64'(p_in);
      else den_ff <= den_in;
   end

   assign req_stall = (state_ff != crsa_pkg::S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(N)) else $error("stack count beyond depth");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == crsa_pkg::S_IDLE) else $error("busy while response pending");
   a_clr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == crsa_pkg::S_WRITE && req_ff.op == crsa_pkg::OP_CLR) |=> cnt_ff == '0)
      else $error("clear did not empty stack");
endmodule
`default_nettype wire

@@ src/crsa_cell.sv @@
// One stack cell: holds one complex element and shifts to its neighbors.
// Depends on crsa_pkg.
`default_nettype none
module crsa_cell (
   input  wire logic                     clock,
   input  wire crsa_pkg::cell_ctl_type   ctl,
   input  wire logic [63:0]              above_data,
   input  wire logic [63:0]              below_data,
   input  wire logic                     is_top,
   output logic [63:0]                   data
);
   logic [63:0] data_ff, data_in;
   // cell 0 is the top; push moves everything one step down
   always_comb begin
      data_in = data_ff;
      case (ctl.shift)
         crsa_pkg::SH_PUSH: data_in = is_top ? ctl.data : above_data;
         crsa_pkg::SH_POP:  data_in = is_top ? ctl.data : below_data;
         default:           data_in = data_ff;
      endcase
   end
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end
   assign data = data_ff;
endmodule
`default_nettype wire

@@ src/crsa_div.sv @@
// Restoring divider for the fixed point quotient, one bit per cycle.
// Depends on crsa_pkg.
`default_nettype none
module crsa_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] num,
   input  wire logic [63:0] den,
   output logic             done,
   output logic [32:0]      quot
);
   localparam int QW = 64 + crsa_pkg::FracBits;
   logic [QW-1:0] n_ff, n_in;
   logic [64:0]   r_ff, r_in;
   logic [QW-1:0] q_ff, q_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [64:0]   trial;

   always_comb begin
      n_in = n_ff; r_in = r_ff; q_in = q_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      trial = {r_ff[63:0], n_ff[QW-1]};
      if (start) begin
         n_in = {num, {crsa_pkg::FracBits{1'b0}}};
         r_in = '0; q_in = '0; cnt_in = 7'(QW); busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in = n_ff << 1;
         if (trial >= {1'b0, den}) begin
            r_in = trial - {1'b0, den};
            q_in = {q_ff[QW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      n_ff <= n_in; r_ff <= r_in; q_ff <= q_in;
   end
   assign done = busy_ff && cnt_ff == 7'd1;
   // clamp to 2^32 when the quotient overflows 32 bits
   assign quot = (|q_in[QW-1:32]) ? 33'h1_0000_0000 : {1'b0, q_in[31:0]};
endmodule
`default_nettype wire
